// ===== design/pdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types and codes of the pixel deglitch filter
// ----------------------------------------------------------------------------
package pdf_pkg;

  // configuration register indexes
  localparam logic REG_IMAGE_COLS = 1'b0;
  localparam logic REG_IMAGE_ROWS = 1'b1;

  // input word kinds carried on tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  // which neighbors of the center pixel exist
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_present_t;

endpackage

// ===== design/pdf_avg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_avg
// glitch test and rounded neighbor average, two register stages
// ----------------------------------------------------------------------------
module pdf_avg import pdf_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [PIXEL_BITS-1:0] center,
  input  logic [PIXEL_BITS-1:0] nb_up,
  input  logic [PIXEL_BITS-1:0] nb_down,
  input  logic [PIXEL_BITS-1:0] nb_left,
  input  logic [PIXEL_BITS-1:0] nb_right,
  input  nb_present_t           present,
  output logic [PIXEL_BITS-1:0] value,
  output logic                  glitch
);

  localparam int SUM_W = PIXEL_BITS + 2;
  localparam int RECIP_SHIFT = SUM_W;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** RECIP_SHIFT) / 3);

  logic [PIXEL_BITS-1:0] nb_val [4];
  logic [3:0]            nb_on;
  logic [3:0]            far;
  logic [SUM_W-1:0]      sum;
  logic [2:0]            n;

  logic [SUM_W-1:0]      sum_q;
  logic [2:0]            n_q;
  logic                  glitch_q;
  logic [PIXEL_BITS-1:0] center_q;
  logic [2*SUM_W-1:0]    prod_q;

  logic [SUM_W-1:0]      sum_p1;
  logic [SUM_W-1:0]      sum_p2;
  logic [SUM_W-1:0]      q0;
  logic [SUM_W-1:0]      rem;
  logic [SUM_W-1:0]      q3;
  logic [SUM_W-1:0]      avg;

  assign nb_val[0] = nb_up;
  assign nb_val[1] = nb_down;
  assign nb_val[2] = nb_left;
  assign nb_val[3] = nb_right;
  assign nb_on = {present.right, present.left, present.down, present.up};

  always_comb begin
    logic [PIXEL_BITS-1:0] diff;
    sum = '0;
    n   = '0;
    for (int i = 0; i < 4; i++) begin
      diff = (center > nb_val[i]) ? center - nb_val[i] : nb_val[i] - center;
      far[i] = !nb_on[i] || (diff > PIXEL_BITS'(1));
      if (nb_on[i]) begin
        sum = sum + SUM_W'(nb_val[i]);
        n   = n + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_q    <= sum;
      n_q      <= n;
      glitch_q <= (n != 3'd0) && (&far);
      center_q <= center;
    end
  end

  assign sum_p1 = sum_q + SUM_W'(1);
  assign sum_p2 = sum_q + SUM_W'(2);

  // divide by three through a reciprocal, corrected by one step
  always_ff @(posedge clk) begin
    if (step) begin
      prod_q <= (2*SUM_W)'(sum_p1) * (2*SUM_W)'(RECIP);
    end
  end

  assign q0  = prod_q[2*SUM_W-1:RECIP_SHIFT];
  assign rem = sum_p1 - ((q0 << 1) + q0);
  assign q3  = (rem >= SUM_W'(3)) ? q0 + SUM_W'(1) : q0;

  always_comb begin
    case (n_q)
      3'd1:    avg = sum_q;
      3'd2:    avg = sum_p1 >> 1;
      3'd3:    avg = q3;
      3'd4:    avg = sum_p2 >> 2;
      default: avg = sum_q;
    endcase
  end

  assign glitch = glitch_q;
  assign value  = glitch_q ? avg[PIXEL_BITS-1:0] : center_q;

endmodule

// ===== design/pixel_deglitch_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_deglitch_filter
// four-neighbor glitch filter on a raster-order pixel stream
//
// input words arrive on s_axis: tuser selects a pixel word or a drain word,
// tdata carries the raw pixel. corrected pixels leave on m_axis with tuser
// set when the pixel was replaced and tlast on the final pixel of a frame.
// image size is set through the cfg write channel (index 0 columns,
// index 1 rows); the user must write it only while the block is idle, which
// the block itself does not enforce. each input word passes accept with
// line buffer reads, glitch test, divide-by-three multiply, then write-back
// of both line buffers, which also loads a released pixel into m_axis.
// output lags input by one image row: the pixel of a row comes out when the
// pixel below it arrives; drain words flush the final row.
// an output register holds a finished pixel, so the next word is accepted
// while it waits; write-back stalls only when a new result meets a full
// output register with m_axis_tready low.
// reset clears counters and control; line buffers are not cleared.
// ----------------------------------------------------------------------------
module pixel_deglitch_filter import pdf_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,  // pixel_in
  input  logic                                s_axis_tuser,  // operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,  // pixel_out
  output logic                                m_axis_tuser,  // was_replaced
  output logic                                m_axis_tlast,  // last_of_frame
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);

  logic [10:0] image_cols;
  logic [15:0] image_rows;
  logic [CNT_W-1:0] cols;
  logic [15:0]      rows;

  state_t state;
  state_t state_next;

  logic [COL_W-1:0]      in_col;
  logic [COL_W-1:0]      out_col;
  logic [15:0]           out_row;
  logic [CNT_W-1:0]      pending;
  logic [PIXEL_BITS-1:0] left_corr;

  logic                  op_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  emit_q;
  logic                  last_q;
  nb_present_t           present_q;

  logic [PIXEL_BITS-1:0] upper_line  [MAX_COLS];
  logic [PIXEL_BITS-1:0] middle_line [MAX_COLS];
  logic [PIXEL_BITS-1:0] mid_rd;
  logic [PIXEL_BITS-1:0] right_rd;
  logic [PIXEL_BITS-1:0] up_rd;

  logic [PIXEL_BITS-1:0] avg_value;
  logic                  avg_glitch;

  logic [PIXEL_BITS-1:0] out_pix;
  logic                  s_fire;
  logic                  wb_fire;
  logic [CNT_W-1:0]      out_col_inc;
  logic [CNT_W-1:0]      in_col_inc;
  logic [16:0]           out_row_inc;
  logic [COL_W-1:0]      right_addr;

  // effective image size
  always_comb begin
    if (image_cols == '0) begin
      cols = CNT_W'(1);
    end else if (32'(image_cols) > MAX_COLS) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(image_cols);
    end
    rows = (image_rows == '0) ? 16'd1 : image_rows;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= 11'd640;
      image_rows <= 16'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_COLS: image_cols <= cfg_data[10:0];
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign wb_fire = (state == S_WB) && !(emit_q && m_axis_tvalid && !m_axis_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_fire) state_next = S_READ;
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = S_WB;
      S_WB:    if (wb_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_col_inc = CNT_W'(out_col) + CNT_W'(1);
  assign in_col_inc  = CNT_W'(in_col) + CNT_W'(1);
  assign out_row_inc = {1'b0, out_row} + 17'd1;
  assign right_addr  = COL_W'(out_col_inc);

  // decode the word against the current position
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op_q  <= s_axis_tuser;
      pix_q <= s_axis_tdata[PIXEL_BITS-1:0];
      if (s_axis_tuser == OP_DRAIN) begin
        emit_q <= (pending != '0);
      end else begin
        emit_q <= (pending >= cols);
      end
      present_q.up    <= (out_row != '0);
      present_q.down  <= (s_axis_tuser == OP_PIXEL) && (out_row_inc < {1'b0, rows});
      present_q.left  <= (out_col != '0);
      present_q.right <= (out_col_inc < cols) && (pending >= CNT_W'(2));
      last_q <= (out_row_inc == {1'b0, rows}) && (out_col_inc == cols);
    end
  end

  // line buffer reads
  always_ff @(posedge clk) begin
    if (s_fire) begin
      mid_rd   <= middle_line[out_col];
      right_rd <= middle_line[right_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      up_rd <= upper_line[out_col];
    end
  end

  // line buffer writes
  always_ff @(posedge clk) begin
    if (wb_fire && (op_q == OP_PIXEL)) begin
      middle_line[in_col] <= pix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire && emit_q) begin
      upper_line[out_col] <= avg_value;
    end
  end

  pdf_avg #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_avg (
    .clk      (clk),
    .load     (state == S_READ),
    .step     (state == S_CALC),
    .center   (mid_rd),
    .nb_up    (up_rd),
    .nb_down  (pix_q),
    .nb_left  (left_corr),
    .nb_right (right_rd),
    .present  (present_q),
    .value    (avg_value),
    .glitch   (avg_glitch)
  );

  // position counters and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      pending   <= '0;
      left_corr <= '0;
    end else if (wb_fire) begin
      if (emit_q) begin
        left_corr <= avg_value;
        if (out_col_inc >= cols) begin
          out_col <= '0;
          out_row <= (out_row_inc >= {1'b0, rows}) ? 16'd0 : out_row_inc[15:0];
        end else begin
          out_col <= COL_W'(out_col_inc);
        end
      end
      if (op_q == OP_PIXEL) begin
        in_col <= (in_col_inc >= cols) ? '0 : COL_W'(in_col_inc);
        if (!emit_q) begin
          pending <= pending + CNT_W'(1);
        end
      end else if (emit_q) begin
        pending <= pending - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (wb_fire && emit_q) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire && emit_q) begin
      out_pix      <= avg_value;
      m_axis_tuser <= avg_glitch;
      m_axis_tlast <= last_q;
    end
  end

  assign m_axis_tdata = DATA_W'(out_pix);

endmodule
